// File: rtl/core/deq_pkg.sv
// shared constants, codes and command/status types for the bounded deque engine
// depends on nothing; used by the interfaces, controller, datapath and top level
package deq_pkg;

  localparam int unsigned DEPTH     = 8;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W     = 4;
  localparam int unsigned CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned DATA_W    = 32;

  typedef logic [1:0]        cmd_t;
  typedef logic [1:0]        status_t;
  typedef logic [CAP_W-1:0]  cap_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cap_t    CAP_RESET   = cap_t'(5);

  localparam cmd_t    CMD_PUSH    = 2'd0;
  localparam cmd_t    CMD_POP     = 2'd1;
  localparam cmd_t    CMD_DISP    = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    RES_OK,
    RES_OVF,
    RES_UNF,
    RES_RAM
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     push;
    logic     pop;
    logic     disp_start;
    logic     disp_next;
    logic     load_res;
    res_sel_e res_sel;
    logic     res_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic disp_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/deq_if.sv
// handshake channel interfaces: command input, result output, capacity write
// depends on deq_pkg for field widths
interface deq_in_if;
  logic                           valid;
  logic                           ready;
  deq_pkg::cmd_t                  cmd;
  logic                           at_front;
  logic signed [deq_pkg::DATA_W-1:0] value;

  modport source (output valid, cmd, at_front, value, input ready);
  modport sink   (input valid, cmd, at_front, value, output ready);
endinterface

interface deq_out_if;
  logic                           valid;
  logic                           ready;
  deq_pkg::status_t               status;
  logic signed [deq_pkg::DATA_W-1:0] value_res;
  logic                           last;

  modport source (output valid, status, value_res, last, input ready);
  modport sink   (input valid, status, value_res, last, output ready);
endinterface

interface deq_cfg_if;
  logic          valid;
  logic          ready;
  deq_pkg::cap_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/deq_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module deq_ram #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned NUM_WORDS  = 8
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(NUM_WORDS)-1:0] waddr_i,
  input  logic [DATA_WIDTH-1:0]        wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(NUM_WORDS)-1:0] raddr_i,
  output logic [DATA_WIDTH-1:0]        rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [NUM_WORDS];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/deq_ctrl.sv
// controller: decodes commands, sequences ram reads for pop and display
// depends on deq_pkg
module deq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  deq_pkg::cmd_t       in_cmd_i,
  output logic                in_ready_o,
  input  deq_pkg::dp_status_t stat_i,
  output deq_pkg::dp_cmd_t    cmd_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   pop_q, pop_d;
  logic   rd_last;

  always_comb begin
    state_d    = state_q;
    pop_d      = pop_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.res_sel  = RES_OK;
    cmd_o.res_last = 1'b1;
    rd_last    = pop_q || stat_i.disp_last;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          case (in_cmd_i)
            CMD_PUSH: begin
              cmd_o.load_res = 1'b1;
              if (stat_i.full) begin
                cmd_o.res_sel = RES_OVF;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            CMD_POP: begin
              if (stat_i.empty) begin
                cmd_o.load_res = 1'b1;
                cmd_o.res_sel  = RES_UNF;
              end else begin
                cmd_o.pop = 1'b1;
                pop_d     = 1'b1;
                state_d   = ST_READ;
              end
            end
            CMD_DISP: begin
              if (stat_i.empty) begin
                cmd_o.load_res = 1'b1;
                cmd_o.res_sel  = RES_UNF;
              end else begin
                cmd_o.disp_start = 1'b1;
                pop_d            = 1'b0;
                state_d          = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (stat_i.out_free) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_sel  = RES_RAM;
          cmd_o.res_last = rd_last;
          if (rd_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.disp_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
    end
  end

endmodule

// File: rtl/core/deq_dp.sv
// datapath: circular store, front index, count, capacity and result register
// depends on deq_pkg and deq_ram
module deq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  deq_pkg::dp_cmd_t                  cmd_i,
  output deq_pkg::dp_status_t               stat_o,
  input  logic                              at_front_i,
  input  logic signed [deq_pkg::DATA_W-1:0] value_i,
  input  logic                              cap_we_i,
  input  deq_pkg::cap_t                     cap_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output deq_pkg::status_t                  status_o,
  output logic signed [deq_pkg::DATA_W-1:0] value_res_o,
  output logic                              last_o
);
  import deq_pkg::*;

  function automatic idx_t slot_wrap(idx_t base, idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  idx_t  front_q;
  cnt_t  count_q, idx_q;
  cap_t  cap_q;
  logic  dir_q;

  logic                       out_valid_q;
  status_t                    status_q;
  logic signed [DATA_W-1:0]   value_res_q;
  logic                       last_q;

  logic [CMP_W-1:0] cap_eff;
  idx_t             front_dec, front_inc, waddr, raddr;
  cnt_t             rd_i, rd_off;
  logic             rd_dir, ram_re, out_free;
  logic [DATA_W-1:0] rdata;

  assign cap_eff   = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
  assign out_free  = !out_valid_q || out_ready_i;

  assign stat_o.full      = CMP_W'(count_q) >= cap_eff;
  assign stat_o.empty     = count_q == '0;
  assign stat_o.disp_last = (idx_q + cnt_t'(1)) == count_q;
  assign stat_o.out_free  = out_free;

  assign front_dec = (front_q == '0) ? idx_t'(DEPTH - 1) : front_q - idx_t'(1);
  assign front_inc = slot_wrap(front_q, idx_t'(1));
  assign waddr     = at_front_i ? front_dec : slot_wrap(front_q, count_q[IDX_W-1:0]);

  assign rd_i   = cmd_i.disp_next ? idx_q + cnt_t'(1) : '0;
  assign rd_dir = (cmd_i.pop || cmd_i.disp_start) ? at_front_i : dir_q;
  assign rd_off = rd_dir ? rd_i : count_q - cnt_t'(1) - rd_i;
  assign raddr  = slot_wrap(front_q, rd_off[IDX_W-1:0]);
  assign ram_re = cmd_i.pop || cmd_i.disp_start || cmd_i.disp_next;

  deq_ram #(
    .DATA_WIDTH (DATA_W),
    .NUM_WORDS  (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      dir_q       <= 1'b0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cap_we_i) begin
        cap_q <= cap_data_i;
      end
      if (cmd_i.push) begin
        count_q <= count_q + cnt_t'(1);
        if (at_front_i) begin
          front_q <= front_dec;
        end
      end
      if (cmd_i.pop) begin
        count_q <= count_q - cnt_t'(1);
        if (at_front_i) begin
          front_q <= front_inc;
        end
      end
      if (cmd_i.disp_start) begin
        idx_q <= '0;
        dir_q <= at_front_i;
      end
      if (cmd_i.disp_next) begin
        idx_q <= rd_i;
      end
      if (cmd_i.load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      last_q <= cmd_i.res_last;
      case (cmd_i.res_sel)
        RES_OVF: begin
          status_q    <= ST_OVERFLOW;
          value_res_q <= '0;
        end
        RES_UNF: begin
          status_q    <= ST_UNDERFLOW;
          value_res_q <= '0;
        end
        RES_RAM: begin
          status_q    <= ST_OK;
          value_res_q <= signed'(rdata);
        end
        default: begin
          status_q    <= ST_OK;
          value_res_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_res_o = value_res_q;
  assign last_o      = last_q;

endmodule

// File: rtl/core/bounded_deque_engine_top.sv
// top level of the bounded deque engine: controller, datapath and channels
// depends on deq_pkg, deq_if, deq_ctrl, deq_dp
//
//   channel  dir  fields                     transfer when
//   in_i     in   cmd, at_front, value       valid && ready
//   out_o    out  status, value_res, last    valid && ready
//   cfg_i    in   data (capacity)            valid && ready (ready tied high)
//
// push and error results are loaded from the idle state; pop passes through the
// read state for the registered read of the entry store ram; display walks the
// held entries in the read state, one ram read per entry
// a result waiting in the output register does not block a new command if it
// is taken the same cycle; a stalled output holds the display sequence
// reset is asynchronous active low: queue empty, front at zero, capacity 5
module bounded_deque_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_in_if.sink     in_i,
  deq_out_if.source  out_o,
  deq_cfg_if.sink    cfg_i
);
  import deq_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_stat;

  assign cfg_i.ready = 1'b1;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  deq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .at_front_i  (in_i.at_front),
    .value_i     (in_i.value),
    .cap_we_i    (cfg_i.valid),
    .cap_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_o    (out_o.status),
    .value_res_o (out_o.value_res),
    .last_o      (out_o.last)
  );

endmodule
